@@ rtl/e2rm_pkg.sv @@
// Package for the Euler-angle rotation matrix block: payload types, Q30 constants, product helper.
`default_nettype none
package e2rm_pkg;

	localparam int W  = 34;
	localparam int ZW = 35;
	localparam int ATAN_COUNT = 24;

	localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [W-1:0]  Q30_GAIN    = 34'sd652032874;

	localparam logic [31:0] ATAN_Q30 [0:ATAN_COUNT-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] m0;
		logic signed [15:0] m1;
		logic signed [15:0] m2;
		logic signed [15:0] m4;
		logic signed [15:0] m5;
		logic signed [15:0] m6;
		logic signed [15:0] m8;
		logic signed [15:0] m9;
		logic signed [15:0] m10;
	} matrix_t;

	// Q30 x Q30 -> Q30, round half up
	function automatic logic signed [W-1:0] mul30(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b + 68'sd536870912;
		return p[W+29:30];
	endfunction

endpackage
`default_nettype wire

@@ rtl/euler_to_rotation_matrix.sv @@
// Top level: Euler angles (ZYX) to the 3x3 rotation matrix, fully pipelined.
// Usage:
//   Input beat: angles (pitch x, yaw y, roll z, Q4.12 radians) is taken at
//   every rising edge with start high and busy low. busy is always low: a
//   new beat may enter on every cycle.
//   Output beat: matrix holds the nine Q1.14 entries of Rx*Ry*Rz while valid
//   is high for one cycle; the receiver takes it at that cycle's end and
//   cannot stall it, so nothing here ever waits.
// Pipeline: the angle range reduction register, the CORDIC micro-rotation
//   stages (TRIG_STAGES of them, capped CORDIC depth of 24), then three
//   product / rounding stages. Throughput: one beat per cycle.
// Stages after the CORDIC are numbered _s1.._s3:
//   s1  sine/cosine sign fix and the ten two-factor products
//   s2  the four three-factor products
//   s3  sums, round to OUT_FRAC_BITS, clamp to +/-1.0 (output register)
// Reset clears only the valid bits; in-flight beats are dropped.
`default_nettype none
module euler_to_rotation_matrix #(
	parameter int TRIG_STAGES   = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  e2rm_pkg::angles_t angles,
	output logic              valid,
	output e2rm_pkg::matrix_t matrix
);
	import e2rm_pkg::*;

	localparam int NS  = (TRIG_STAGES > ATAN_COUNT) ? ATAN_COUNT : TRIG_STAGES;
	localparam int LAT = NS + 4;
	localparam int SH  = 30 - OUT_FRAC_BITS;
	localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
	localparam logic signed [35:0] ONE = 36'sd1 <<< OUT_FRAC_BITS;

	assign busy = 1'b0;

	// index 0 = reduced angle, index k+1 = after micro-rotation k
	logic signed [W-1:0]  x_s [0:NS][0:2];
	logic signed [W-1:0]  y_s [0:NS][0:2];
	logic signed [ZW-1:0] z_s [0:NS][0:2];
	logic                 f_s [0:NS][0:2];
	logic                 v_s [0:NS];

	logic signed [15:0] ang [0:2];
	assign ang[0] = angles.angle_x;
	assign ang[1] = angles.angle_y;
	assign ang[2] = angles.angle_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= start & ~busy;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_red
		logic signed [ZW-1:0] zw, zr, zf;
		logic                 flip;
		always_comb begin
			zw = {ang[a][15], ang[a], 18'b0};
			if (zw > Q30_PI)       zr = zw - Q30_TWO_PI;
			else if (zw < -Q30_PI) zr = zw + Q30_TWO_PI;
			else                   zr = zw;
			flip = 1'b1;
			if (zr > Q30_HALF_PI)       zf = zr - Q30_PI;
			else if (zr < -Q30_HALF_PI) zf = zr + Q30_PI;
			else begin
				zf   = zr;
				flip = 1'b0;
			end
		end
		always_ff @(posedge clk) begin
			x_s[0][a] <= Q30_GAIN;
			y_s[0][a] <= '0;
			z_s[0][a] <= zf;
			f_s[0][a] <= flip;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_cordic
		localparam logic signed [ZW-1:0] ATN = $signed({3'b000, ATAN_Q30[k]});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		for (genvar a = 0; a < 3; a++) begin : g_ax
			logic signed [W-1:0] dx, dy;
			assign dx = y_s[k][a] >>> k;
			assign dy = x_s[k][a] >>> k;
			always_ff @(posedge clk) begin
				f_s[k+1][a] <= f_s[k][a];
				if (!z_s[k][a][ZW-1]) begin
					x_s[k+1][a] <= x_s[k][a] - dx;
					y_s[k+1][a] <= y_s[k][a] + dy;
					z_s[k+1][a] <= z_s[k][a] - ATN;
				end else begin
					x_s[k+1][a] <= x_s[k][a] + dx;
					y_s[k+1][a] <= y_s[k][a] - dy;
					z_s[k+1][a] <= z_s[k][a] + ATN;
				end
			end
		end
	end

	// sine / cosine with quadrant fold undone
	logic signed [W-1:0] sn [0:2];
	logic signed [W-1:0] cs [0:2];
	for (genvar a = 0; a < 3; a++) begin : g_sc
		assign sn[a] = f_s[NS][a] ? -y_s[NS][a] : y_s[NS][a];
		assign cs[a] = f_s[NS][a] ? -x_s[NS][a] : x_s[NS][a];
	end

	logic                v_s1, v_s2, valid_q;
	logic signed [W-1:0] cycz_s1, cxsz_s1, cxcz_s1, sxsz_s1, sxcz_s1, cysz_s1;
	logic signed [W-1:0] sxcy_s1, cxcy_s1, sxsy_s1, cxsy_s1, cz_s1, sz_s1, sy_s1;
	logic signed [W-1:0] cycz_s2, cxsz_s2, cxcz_s2, sxsz_s2, sxcz_s2, cysz_s2;
	logic signed [W-1:0] sxcy_s2, cxcy_s2, sy_s2, t1_s2, t2_s2, t3_s2, t4_s2;
	matrix_t             matrix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1    <= v_s[NS];
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cycz_s1 <= mul30(cs[1], cs[2]);
		cxsz_s1 <= mul30(cs[0], sn[2]);
		cxcz_s1 <= mul30(cs[0], cs[2]);
		sxsz_s1 <= mul30(sn[0], sn[2]);
		sxcz_s1 <= mul30(sn[0], cs[2]);
		cysz_s1 <= mul30(cs[1], sn[2]);
		sxcy_s1 <= mul30(sn[0], cs[1]);
		cxcy_s1 <= mul30(cs[0], cs[1]);
		sxsy_s1 <= mul30(sn[0], sn[1]);
		cxsy_s1 <= mul30(cs[0], sn[1]);
		cz_s1   <= cs[2];
		sz_s1   <= sn[2];
		sy_s1   <= sn[1];
	end

	always_ff @(posedge clk) begin
		t1_s2   <= mul30(sxsy_s1, cz_s1);
		t2_s2   <= mul30(sxsy_s1, sz_s1);
		t3_s2   <= mul30(cxsy_s1, cz_s1);
		t4_s2   <= mul30(cxsy_s1, sz_s1);
		cycz_s2 <= cycz_s1;
		cxsz_s2 <= cxsz_s1;
		cxcz_s2 <= cxcz_s1;
		sxsz_s2 <= sxsz_s1;
		sxcz_s2 <= sxcz_s1;
		cysz_s2 <= cysz_s1;
		sxcy_s2 <= sxcy_s1;
		cxcy_s2 <= cxcy_s1;
		sy_s2   <= sy_s1;
	end

	// round Q30 to OUT_FRAC_BITS, clamp to +/-1.0, keep low 16 bits
	function automatic logic [15:0] to_out(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + RND) >>> SH;
		if (r > ONE)  r = ONE;
		if (r < -ONE) r = -ONE;
		return r[15:0];
	endfunction

	function automatic logic signed [35:0] ext(input logic signed [W-1:0] v);
		return {{(36-W){v[W-1]}}, v};
	endfunction

	always_ff @(posedge clk) begin
		matrix_q.m0  <= to_out(ext(cycz_s2));
		matrix_q.m1  <= to_out(ext(t1_s2) + ext(cxsz_s2));
		matrix_q.m2  <= to_out(ext(sxsz_s2) - ext(t3_s2));
		matrix_q.m4  <= to_out(-ext(cysz_s2));
		matrix_q.m5  <= to_out(ext(cxcz_s2) - ext(t2_s2));
		matrix_q.m6  <= to_out(ext(t4_s2) + ext(sxcz_s2));
		matrix_q.m8  <= to_out(ext(sy_s2));
		matrix_q.m9  <= to_out(-ext(sxcy_s2));
		matrix_q.m10 <= to_out(ext(cxcy_s2));
	end

	assign valid  = valid_q;
	assign matrix = matrix_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start, LAT))
		else $error("result beat without a matching start");
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, LAT) && $past(arst_n, LAT) && $past(arst_n, 1) |-> valid)
		else $error("accepted beat lost in pipeline");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (OUT_FRAC_BITS <= 14) |->
		($signed(matrix.m8) <= ONE) && ($signed(matrix.m8) >= -ONE) &&
		($signed(matrix.m0) <= ONE) && ($signed(matrix.m0) >= -ONE))
		else $error("matrix entry outside +/-1.0");

endmodule
`default_nettype wire
